// ===== design/pds_pkg.sv =====
// ----------------------------------------------------------------------------
// pds_pkg: shared constants and types for the point depth sorter
// Register indexes, key layout and the key ordering helper.
// ----------------------------------------------------------------------------
package pds_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int CFG_IDX_W      = 2;
	localparam int IDX_W          = 6;
	localparam int DEPTH_W        = 32;
	localparam int KEY_W          = DEPTH_W + 1;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_Z = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd3;

	localparam logic signed [DEPTH_W-1:0] COEF_Z_RESET = 32'sd65536;

	typedef struct packed {
		logic                      inv;
		logic signed [DEPTH_W-1:0] depth;
	} key_t;

	typedef struct packed {
		logic             key_inv;
		logic [IDX_W-1:0] idx;
		key_t             key;
	} entry_t;

	// true if a must come strictly after b
	function automatic logic key_after(input key_t a, input key_t b);
		if (a.inv)
			return !b.inv;
		if (b.inv)
			return 1'b0;
		return a.depth > b.depth;
	endfunction

endpackage

// ===== design/point_depth_sort.sv =====
// ----------------------------------------------------------------------------
// point_depth_sort: view depth sort of a point set
// Each point passes the depth pipeline, then an insertion that walks the key
// memory down from the top, moving each stored key that sorts after it up one
// address. A new point is taken only once the previous one is inserted or dropped;
// after the last point the sorted run streams one index at a time, held while
// out_stall is high. Reset clears the counts, state and flags and sets the config
// registers to their reset values, but not the memory or the data registers.
// ----------------------------------------------------------------------------
module point_depth_sort #(
	parameter int MAX_POINTS = pds_pkg::MAX_POINTS_DEF,
	parameter int FRAC_BITS  = pds_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [pds_pkg::DEPTH_W-1:0]  pos_x,
	input  logic signed [pds_pkg::DEPTH_W-1:0]  pos_y,
	input  logic signed [pds_pkg::DEPTH_W-1:0]  pos_z,
	input  logic                                pos_invalid,
	input  logic                                last_point,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [pds_pkg::IDX_W-1:0]           point_index,
	output logic signed [pds_pkg::DEPTH_W-1:0]  depth_key,
	output logic                                key_invalid,
	output logic                                overflow,
	output logic                                last_result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pds_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pds_pkg::DEPTH_W-1:0]         cfg_data
);
	logic signed [pds_pkg::DEPTH_W-1:0] coef_x_q, coef_y_q, coef_z_q, offset_q;
	logic signed [pds_pkg::DEPTH_W-1:0] depth;
	logic        acc, dvld, busy, pend_q, inv_q, last_q;
	pds_pkg::key_t key;

	assign cfg_ready = 1'b1;
	assign in_stall  = pend_q || busy;
	assign acc       = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_x_q <= '0;
			coef_y_q <= '0;
			coef_z_q <= pds_pkg::COEF_Z_RESET;
			offset_q <= '0;
			pend_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					pds_pkg::REG_COEF_X: coef_x_q <= cfg_data;
					pds_pkg::REG_COEF_Y: coef_y_q <= cfg_data;
					pds_pkg::REG_COEF_Z: coef_z_q <= cfg_data;
					pds_pkg::REG_OFFSET: offset_q <= cfg_data;
					default: ;
				endcase
			end
			if (acc)
				pend_q <= 1'b1;
			else if (dvld)
				pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			inv_q  <= pos_invalid;
			last_q <= last_point;
		end
	end

	pds_depth #(.FRAC_BITS(FRAC_BITS)) u_depth (
		.clk(clk), .arst_n(arst_n), .in_vld(acc),
		.x(pos_x), .y(pos_y), .z(pos_z),
		.cx(coef_x_q), .cy(coef_y_q), .cz(coef_z_q), .coff(offset_q),
		.out_vld(dvld), .depth(depth)
	);

	assign key.inv   = inv_q;
	assign key.depth = depth;

	pds_store #(.MAX_POINTS(MAX_POINTS)) u_store (
		.clk(clk), .arst_n(arst_n),
		.ins_vld(dvld), .ins_key(key), .ins_drop(1'b0), .ins_last(last_q),
		.busy(busy), .out_valid(out_valid), .out_stall(out_stall),
		.out_idx(point_index), .out_depth(depth_key), .out_inv(key_invalid),
		.out_ovf(overflow), .out_last(last_result)
	);
endmodule

// ===== design/pds_depth.sv =====
// ----------------------------------------------------------------------------
// pds_depth: view depth pipeline
// Three products in stage 1, sum in stage 2, floor shift and saturate in 3.
// ----------------------------------------------------------------------------
module pds_depth #(
	parameter int FRAC_BITS = pds_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_vld,
	input  logic signed [pds_pkg::DEPTH_W-1:0]  x,
	input  logic signed [pds_pkg::DEPTH_W-1:0]  y,
	input  logic signed [pds_pkg::DEPTH_W-1:0]  z,
	input  logic signed [pds_pkg::DEPTH_W-1:0]  cx,
	input  logic signed [pds_pkg::DEPTH_W-1:0]  cy,
	input  logic signed [pds_pkg::DEPTH_W-1:0]  cz,
	input  logic signed [pds_pkg::DEPTH_W-1:0]  coff,
	output logic                                out_vld,
	output logic signed [pds_pkg::DEPTH_W-1:0]  depth
);
	localparam int SUM_W = 68;

	logic signed [63:0]      px_s1, py_s1, pz_s1;
	logic signed [63:0]      po_s1;
	logic signed [SUM_W-1:0] sum_s2;
	logic                    vld_s1, vld_s2;
	logic signed [SUM_W-1:0] shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			out_vld <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		px_s1  <= cx * x;
		py_s1  <= cy * y;
		pz_s1  <= cz * z;
		po_s1  <= 64'(signed'(coff)) <<< FRAC_BITS;
		sum_s2 <= SUM_W'(px_s1) + SUM_W'(py_s1) + SUM_W'(pz_s1) + SUM_W'(po_s1);
	end

	assign shifted = sum_s2 >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (shifted > SUM_W'(64'sh7FFFFFFF))
			depth <= 32'sh7FFFFFFF;
		else if (shifted < -SUM_W'(64'sh80000000))
			depth <= 32'sh80000000;
		else
			depth <= shifted[pds_pkg::DEPTH_W-1:0];
	end
endmodule

// ===== design/pds_store.sv =====
// ----------------------------------------------------------------------------
// pds_store: sorted key memory with insertion sequencer
// Inserts one key by shifting larger entries up, then streams the run.
// ----------------------------------------------------------------------------
module pds_store #(
	parameter int MAX_POINTS = pds_pkg::MAX_POINTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               ins_vld,
	input  pds_pkg::key_t                      ins_key,
	input  logic                               ins_drop,
	input  logic                               ins_last,
	output logic                               busy,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [pds_pkg::IDX_W-1:0]          out_idx,
	output logic signed [pds_pkg::DEPTH_W-1:0] out_depth,
	output logic                               out_inv,
	output logic                               out_ovf,
	output logic                               out_last
);
	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	typedef enum logic [2:0] {S_IDLE, S_RD, S_CMP, S_EMIT_RD, S_EMIT_W, S_EMIT}
		state_t;

	typedef struct packed {
		pds_pkg::key_t          key;
		logic [pds_pkg::IDX_W-1:0] idx;
	} slot_t;

	slot_t          mem [MAX_POINTS];
	slot_t          rd_q;
	logic [AW-1:0]  raddr;
	logic           we;
	logic [AW-1:0]  waddr;
	slot_t          wdata;

	state_t         state_q;
	logic [CW-1:0]  count_q, pos_q, emit_q;
	logic           ovf_q, last_q;
	pds_pkg::key_t  key_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	always_comb begin
		raddr = AW'(pos_q - CW'(1));
		if (state_q == S_EMIT_RD || state_q == S_EMIT)
			raddr = AW'(emit_q);
		we    = 1'b0;
		waddr = AW'(pos_q);
		wdata = rd_q;
		if (state_q == S_CMP) begin
			we = 1'b1;
			if (!pds_pkg::key_after(rd_q.key, key_q)) begin
				wdata.key = key_q;
				wdata.idx = pds_pkg::IDX_W'(count_q);
			end
		end else if (state_q == S_RD && pos_q == '0) begin
			we        = 1'b1;
			wdata.key = key_q;
			wdata.idx = pds_pkg::IDX_W'(count_q);
		end
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			pos_q     <= '0;
			emit_q    <= '0;
			ovf_q     <= 1'b0;
			last_q    <= 1'b0;
			out_valid <= 1'b0;
			out_last  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (ins_vld) begin
						last_q <= ins_last;
						key_q  <= ins_key;
						if (ins_drop || count_q == CW'(MAX_POINTS)) begin
							ovf_q <= 1'b1;
							if (ins_last) begin
								emit_q  <= '0;
								state_q <= (count_q == '0) ? S_IDLE : S_EMIT_RD;
								if (count_q == '0)
									ovf_q <= 1'b0;
							end
						end else begin
							pos_q   <= count_q;
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					if (pos_q == '0) begin
						count_q <= count_q + CW'(1);
						state_q <= last_q ? S_EMIT_RD : S_IDLE;
						emit_q  <= '0;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (pds_pkg::key_after(rd_q.key, key_q)) begin
						pos_q   <= pos_q - CW'(1);
						state_q <= S_RD;
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= last_q ? S_EMIT_RD : S_IDLE;
						emit_q  <= '0;
					end
				end
				S_EMIT_RD: state_q <= S_EMIT_W;
				S_EMIT_W: begin
					out_valid <= 1'b1;
					out_idx   <= rd_q.idx;
					out_inv   <= rd_q.key.inv;
					out_depth <= rd_q.key.inv ? '0 : rd_q.key.depth;
					out_ovf   <= ovf_q;
					out_last  <= (emit_q + CW'(1) == count_q);
					emit_q    <= emit_q + CW'(1);
					state_q   <= S_EMIT;
				end
				S_EMIT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						if (out_last) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_EMIT_W;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== design/pds_checker.sv =====
// ----------------------------------------------------------------------------
// pds_checker: port-level checks for the point depth sorter
// Watches the result channel and input flow control.
// ----------------------------------------------------------------------------
module pds_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic key_invalid,
	input logic signed [31:0] depth_key,
	input logic last_result
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(depth_key))
		else $error("result changed while stalled");
	a_inv0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_invalid |-> depth_key == '0)
		else $error("invalid key with nonzero depth");
	a_nogap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open during sorted run");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_result |=> in_stall)
		else $error("run ended without last");
endmodule

bind point_depth_sort pds_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .key_invalid(key_invalid),
	.depth_key(depth_key), .last_result(last_result)
);
